// ----- rtl/idea_pkg.sv -----
// ----------------------------------------------------------------------------
// idea_pkg
// Shared types and constants for the IDEA block cipher unit.
// ----------------------------------------------------------------------------
`default_nettype none

package idea_pkg;

   localparam int WORD_W          = 16;
   localparam int KEY_W           = 128;
   localparam int CSR_DATA_W      = 64;
   localparam int CSR_INDEX_W     = 2;
   localparam int SKI_W           = 6;   // subkey index, up to 51
   localparam int ROUND_COUNT_DEF = 8;
   localparam int INV_STEPS       = 15;  // x^(2^16-1): square and multiply 15 times
   localparam int KEY_ROT         = 25;

   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LOW  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_HIGH = 2'd1;

   typedef logic [WORD_W-1:0] word_type;

endpackage : idea_pkg

`default_nettype wire

// ----- rtl/idea_mul.sv -----
// ----------------------------------------------------------------------------
// idea_mul
// Multiplier modulo 65537, where the word zero stands for 65536.
// ----------------------------------------------------------------------------
`default_nettype none

module idea_mul (
   input  idea_pkg::word_type a,
   input  idea_pkg::word_type b,
   output idea_pkg::word_type p
);
   import idea_pkg::*;

   logic [WORD_W:0]     x;
   logic [WORD_W:0]     y;
   logic [2*WORD_W:0]   prod;
   logic [WORD_W:0]     lo;
   logic [WORD_W:0]     hi;
   logic [WORD_W+1:0]   diff;

   assign x    = {(a == '0), a};
   assign y    = {(b == '0), b};
   assign prod = {16'b0, x} * {16'b0, y};
   assign lo   = {1'b0, prod[WORD_W-1:0]};
   assign hi   = prod[2*WORD_W:WORD_W];

   // 2^16 = -1 mod 65537, so the product is lo - hi, folded once
   always_comb begin
      if (lo >= hi) begin
         diff = {1'b0, lo} - {1'b0, hi};
      end else begin
         diff = {1'b0, lo} - {1'b0, hi} + 18'd65537;
      end
   end

   assign p = diff[WORD_W-1:0];

endmodule : idea_mul

`default_nettype wire

// ----- rtl/idea_key.sv -----
// ----------------------------------------------------------------------------
// idea_key
// Encryption subkey selector: slice of the key rotated by 25 bits per group.
// ----------------------------------------------------------------------------
`default_nettype none

module idea_key (
   input  logic [idea_pkg::CSR_DATA_W-1:0] key_lo,
   input  logic [idea_pkg::CSR_DATA_W-1:0] key_hi,
   input  logic [idea_pkg::SKI_W-1:0]      idx,
   output idea_pkg::word_type              subkey
);
   import idea_pkg::*;

   logic [KEY_W-1:0] key;
   logic [KEY_W-1:0] rot;
   logic [KEY_W-1:0] shifted;

   // key word 0 is the most significant word
   assign key = {key_lo[15:0], key_lo[31:16], key_lo[47:32], key_lo[63:48],
                 key_hi[15:0], key_hi[31:16], key_hi[47:32], key_hi[63:48]};

   always_comb begin
      rot = key;
      for (int g = 1; g < 7; g++) begin
         if (idx[SKI_W-1:3] == 3'(g)) begin
            rot = (key << ((KEY_ROT * g) % KEY_W)) |
                  (key >> (KEY_W - ((KEY_ROT * g) % KEY_W)));
         end
      end
   end

   assign shifted = rot >> {(3'd7 - idx[2:0]), 4'd0};
   assign subkey  = shifted[WORD_W-1:0];

endmodule : idea_key

`default_nettype wire

// ----- rtl/idea_block_cipher_unit.sv -----
// ----------------------------------------------------------------------------
// idea_block_cipher_unit
// IDEA block cipher engine, ECB form, one shared modulo-65537 multiplier.
//
// Write key words 0..3 at csr index 0 and words 4..7 at index 1 while idle;
// csr_ready is always high and other indexes are ignored. A req beat carries
// one 64-bit block, a mode bit (0 encrypt, 1 decrypt) and a last-block flag.
// req_ready is high only while the engine is idle; one block is processed at
// a time and the result beat waits in an output register until rsp_ready.
// Each subkey is fetched (ST_FETCH) and then applied (ST_EXEC), plus one
// mixing step (ST_MIX) per round. Decryption also inverts 2*ROUND_COUNT+2
// subkeys, each by 30 passes through the multiplier (ST_SQ, ST_MU), before
// they are applied. The next block is taken once the engine is in ST_IDLE.
// A stalled receiver holds the engine at its last step until the previous
// result is taken. Reset clears the key to zero and empties the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module idea_block_cipher_unit #(
   parameter int ROUND_COUNT = idea_pkg::ROUND_COUNT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_mode,
   input  idea_pkg::word_type                req_word0,
   input  idea_pkg::word_type                req_word1,
   input  idea_pkg::word_type                req_word2,
   input  idea_pkg::word_type                req_word3,
   input  logic                              req_last_block,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output idea_pkg::word_type                rsp_result0,
   output idea_pkg::word_type                rsp_result1,
   output idea_pkg::word_type                rsp_result2,
   output idea_pkg::word_type                rsp_result3,
   output logic                              rsp_final_out,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [idea_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [idea_pkg::CSR_DATA_W-1:0]   csr_data
);
   import idea_pkg::*;

   localparam int RND_W = $clog2(ROUND_COUNT + 1);
   localparam logic [RND_W-1:0] LAST_RND = RND_W'(ROUND_COUNT);
   localparam logic [SKI_W-1:0] DBASE0   = SKI_W'(6 * ROUND_COUNT);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_FETCH = 6'b000010,
      ST_SQ    = 6'b000100,
      ST_MU    = 6'b001000,
      ST_EXEC  = 6'b010000,
      ST_MIX   = 6'b100000
   } state_type;

   state_type           state_ff, state_in;
   logic                mode_ff, mode_in;
   logic                last_ff, last_in;
   word_type            x1_ff, x1_in, x2_ff, x2_in, x3_ff, x3_in, x4_ff, x4_in;
   word_type            t1_ff, t1_in, t2_ff, t2_in;
   word_type            kraw_ff, kraw_in;
   word_type            acc_ff, acc_in;
   logic [3:0]          cnt_ff, cnt_in;
   logic [RND_W-1:0]    rnd_ff, rnd_in;
   logic [2:0]          pos_ff, pos_in;
   logic [SKI_W-1:0]    ebase_ff, ebase_in, dbase_ff, dbase_in;
   logic [CSR_DATA_W-1:0] key_lo_ff, key_lo_in, key_hi_ff, key_hi_in;
   logic                rsp_valid_ff, rsp_valid_in;
   word_type            r0_ff, r0_in, r1_ff, r1_in, r2_ff, r2_in, r3_ff, r3_in;
   logic                rf_ff, rf_in;

   logic [SKI_W-1:0]    kidx;
   word_type            raw_key;
   word_type            mul_a, mul_b, mul_p;
   logic                edge_rnd;
   logic                final_rnd;
   logic                out_free;
   word_type            t2_mix;

   idea_key u_key (
      .key_lo (key_lo_ff),
      .key_hi (key_hi_ff),
      .idx    (kidx),
      .subkey (raw_key)
   );

   idea_mul u_mul (
      .a (mul_a),
      .b (mul_b),
      .p (mul_p)
   );

   assign final_rnd = (rnd_ff == LAST_RND);
   assign edge_rnd  = (rnd_ff == '0) || final_rnd;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign t2_mix    = t1_ff + t2_ff;

   // subkey index for the current round position
   always_comb begin
      kidx = ebase_ff + SKI_W'(pos_ff);
      if (mode_ff) begin
         case (pos_ff)
            3'd0:    kidx = dbase_ff;
            3'd1:    kidx = edge_rnd ? dbase_ff + 6'd1 : dbase_ff + 6'd2;
            3'd2:    kidx = edge_rnd ? dbase_ff + 6'd2 : dbase_ff + 6'd1;
            3'd3:    kidx = dbase_ff + 6'd3;
            3'd4:    kidx = dbase_ff - 6'd2;
            3'd5:    kidx = dbase_ff - 6'd1;
            default: kidx = dbase_ff;
         endcase
      end
   end

   always_comb begin
      mul_a = acc_ff;
      mul_b = acc_ff;
      if (state_ff == ST_MU) begin
         mul_b = kraw_ff;
      end else if (state_ff == ST_EXEC) begin
         mul_b = acc_ff;
         case (pos_ff)
            3'd0:    mul_a = x1_ff;
            3'd3:    mul_a = x4_ff;
            3'd4:    mul_a = x1_ff ^ x3_ff;
            3'd5:    mul_a = t2_ff + (x2_ff ^ x4_ff);
            default: mul_a = x1_ff;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      last_in      = last_ff;
      x1_in        = x1_ff;
      x2_in        = x2_ff;
      x3_in        = x3_ff;
      x4_in        = x4_ff;
      t1_in        = t1_ff;
      t2_in        = t2_ff;
      kraw_in      = kraw_ff;
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      rnd_in       = rnd_ff;
      pos_in       = pos_ff;
      ebase_in     = ebase_ff;
      dbase_in     = dbase_ff;
      key_lo_in    = key_lo_ff;
      key_hi_in    = key_hi_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      r0_in        = r0_ff;
      r1_in        = r1_ff;
      r2_in        = r2_ff;
      r3_in        = r3_ff;
      rf_in        = rf_ff;

      if (csr_valid) begin
         if (csr_index == CSR_KEY_LOW) begin
            key_lo_in = csr_data;
         end else if (csr_index == CSR_KEY_HIGH) begin
            key_hi_in = csr_data;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mode_in  = req_mode;
               last_in  = req_last_block;
               x1_in    = req_word0;
               x2_in    = req_word1;
               x3_in    = req_word2;
               x4_in    = req_word3;
               rnd_in   = '0;
               pos_in   = '0;
               ebase_in = '0;
               dbase_in = DBASE0;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            kraw_in = raw_key;
            acc_in  = raw_key;
            if (mode_ff && (pos_ff == 3'd0 || pos_ff == 3'd3)) begin
               cnt_in   = 4'(INV_STEPS);
               state_in = ST_SQ;
            end else begin
               if (mode_ff && (pos_ff == 3'd1 || pos_ff == 3'd2)) begin
                  acc_in = ~raw_key + 16'd1;
               end
               state_in = ST_EXEC;
            end
         end
         ST_SQ: begin
            acc_in   = mul_p;
            state_in = ST_MU;
         end
         ST_MU: begin
            acc_in   = mul_p;
            cnt_in   = cnt_ff - 4'd1;
            state_in = (cnt_ff == 4'd1) ? ST_EXEC : ST_SQ;
         end
         ST_EXEC: begin
            if (final_rnd) begin
               case (pos_ff)
                  3'd0: x1_in = mul_p;
                  3'd1: x3_in = x3_ff + acc_ff;
                  3'd2: x2_in = x2_ff + acc_ff;
                  default: ;
               endcase
               if (pos_ff == 3'd3) begin
                  // hold until the output register is free
                  if (out_free) begin
                     rsp_valid_in = 1'b1;
                     r0_in        = x1_ff;
                     r1_in        = x3_ff;
                     r2_in        = x2_ff;
                     r3_in        = mul_p;
                     rf_in        = last_ff;
                     state_in     = ST_IDLE;
                  end
               end else begin
                  pos_in   = pos_ff + 3'd1;
                  state_in = ST_FETCH;
               end
            end else begin
               case (pos_ff)
                  3'd0:    x1_in = mul_p;
                  3'd1:    x2_in = x2_ff + acc_ff;
                  3'd2:    x3_in = x3_ff + acc_ff;
                  3'd3:    x4_in = mul_p;
                  3'd4:    t2_in = mul_p;
                  3'd5:    t1_in = mul_p;
                  default: ;
               endcase
               if (pos_ff == 3'd5) begin
                  state_in = ST_MIX;
               end else begin
                  pos_in   = pos_ff + 3'd1;
                  state_in = ST_FETCH;
               end
            end
         end
         ST_MIX: begin
            x1_in    = x1_ff ^ t1_ff;
            x4_in    = x4_ff ^ t2_mix;
            x3_in    = t2_mix ^ x2_ff;
            x2_in    = x3_ff ^ t1_ff;
            rnd_in   = rnd_ff + 1'b1;
            pos_in   = '0;
            ebase_in = ebase_ff + 6'd6;
            dbase_in = dbase_ff - 6'd6;
            state_in = ST_FETCH;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         key_lo_ff    <= '0;
         key_hi_ff    <= '0;
         rnd_ff       <= '0;
         pos_ff       <= '0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         key_lo_ff    <= key_lo_in;
         key_hi_ff    <= key_hi_in;
         rnd_ff       <= rnd_in;
         pos_ff       <= pos_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff  <= mode_in;
      last_ff  <= last_in;
      x1_ff    <= x1_in;
      x2_ff    <= x2_in;
      x3_ff    <= x3_in;
      x4_ff    <= x4_in;
      t1_ff    <= t1_in;
      t2_ff    <= t2_in;
      kraw_ff  <= kraw_in;
      acc_ff   <= acc_in;
      ebase_ff <= ebase_in;
      dbase_ff <= dbase_in;
      r0_ff    <= r0_in;
      r1_ff    <= r1_in;
      r2_ff    <= r2_in;
      r3_ff    <= r3_in;
      rf_ff    <= rf_in;
   end

   assign req_ready     = (state_ff == ST_IDLE);
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_result0   = r0_ff;
   assign rsp_result1   = r1_ff;
   assign rsp_result2   = r2_ff;
   assign rsp_result3   = r3_ff;
   assign rsp_final_out = rf_ff;

   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("engine still ready after taking a block");

   a_round_bound : assert property (@(posedge clock) disable iff (reset)
      rnd_ff <= LAST_RND)
      else $error("round counter past the output transform");

   a_inv_count : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MU) |-> (cnt_ff != 4'd0))
      else $error("inverse step counter ran out");

   a_final_pos : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && final_rnd) |-> (pos_ff <= 3'd3))
      else $error("output transform past its fourth subkey");

endmodule : idea_block_cipher_unit

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the IDEA block cipher unit: a directed table of
// blocks, then random blocks under several keys, each result checked
// against an in-bench IDEA predictor, with random sender and receiver idling.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import idea_pkg::*;

   localparam int ROUNDS     = ROUND_COUNT_DEF;
   localparam int CYCLE_CAP  = 4_000_000;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B = 2'd3;
   localparam logic MODE_ENC = 1'b0;
   localparam logic MODE_DEC = 1'b1;

   typedef word_type subkey_set_type[52];
   typedef struct {
      logic     mode;
      word_type w0, w1, w2, w3;
      logic     last;
   } block_type;
   typedef struct {
      word_type r0, r1, r2, r3;
      logic     fin;
   } cipher_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0, req_ready, req_mode = 1'b0, req_last_block = 1'b0;
   word_type req_word0 = '0, req_word1 = '0, req_word2 = '0, req_word3 = '0;
   logic rsp_valid, rsp_ready = 1'b0, rsp_final_out;
   word_type rsp_result0, rsp_result1, rsp_result2, rsp_result3;
   logic csr_valid = 1'b0, csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   logic [63:0] key_lo = '0, key_hi = '0;
   cipher_out_type pending_blocks[$];
   bit failed = 1'b0;
   longint unsigned cycles = 0;
   word_type last_ct[4] = '{default: '0};

   idea_block_cipher_unit uut (.*);

   always #2 clock = ~clock;

   // ---------------- predictor ----------------
   function automatic word_type mulmod(word_type a, word_type b);
      longint unsigned x, y;
      x = (a == 0) ? 65536 : a;
      y = (b == 0) ? 65536 : b;
      return word_type'((x * y) % 65537);
   endfunction

   function automatic word_type invmod(word_type v);
      longint unsigned base, acc;
      if (v <= 1) return v;
      base = v;
      acc = 1;
      for (int e = 0; e < 16; e++) begin
         acc = (acc * base) % 65537;
         base = (base * base) % 65537;
      end
      return word_type'(acc);
   endfunction

   function automatic subkey_set_type expand_key(logic [63:0] lo, logic [63:0] hi);
      subkey_set_type ek;
      int base, pos;
      for (int k = 0; k < 4; k++) begin
         ek[k] = lo[16*k +: 16];
         ek[k+4] = hi[16*k +: 16];
      end
      for (int k = 8; k < 52; k++) begin
         base = 8 * (k / 8 - 1);
         pos = k % 8;
         ek[k] = {ek[base + ((pos + 1) & 7)][6:0], ek[base + ((pos + 2) & 7)][15:7]};
      end
      return ek;
   endfunction

   function automatic subkey_set_type invert_keys(subkey_set_type ek);
      subkey_set_type dk;
      int s;
      int top;
      top = 6 * ROUNDS;
      dk = ek;
      dk[0] = invmod(ek[top]);
      dk[1] = -ek[top+1];
      dk[2] = -ek[top+2];
      dk[3] = invmod(ek[top+3]);
      for (int r = 1; r < ROUNDS; r++) begin
         s = 6 * (ROUNDS - r);
         dk[6*r-2] = ek[s+4];
         dk[6*r-1] = ek[s+5];
         dk[6*r]   = invmod(ek[s]);
         dk[6*r+1] = -ek[s+2];
         dk[6*r+2] = -ek[s+1];
         dk[6*r+3] = invmod(ek[s+3]);
      end
      dk[top-2] = ek[4];
      dk[top-1] = ek[5];
      dk[top]   = invmod(ek[0]);
      dk[top+1] = -ek[1];
      dk[top+2] = -ek[2];
      dk[top+3] = invmod(ek[3]);
      return dk;
   endfunction

   function automatic cipher_out_type idea_transform(block_type b);
      subkey_set_type sk;
      word_type x1, x2, x3, x4, t1, t2;
      cipher_out_type o;
      int z;
      sk = expand_key(key_lo, key_hi);
      if (b.mode == MODE_DEC) sk = invert_keys(sk);
      x1 = b.w0; x2 = b.w1; x3 = b.w2; x4 = b.w3;
      z = 0;
      for (int r = 0; r < ROUNDS; r++) begin
         x1 = mulmod(x1, sk[z]);
         x2 = x2 + sk[z+1];
         x3 = x3 + sk[z+2];
         x4 = mulmod(x4, sk[z+3]);
         t2 = mulmod(x1 ^ x3, sk[z+4]);
         t1 = mulmod(t2 + (x2 ^ x4), sk[z+5]);
         t2 = t1 + t2;
         x1 = x1 ^ t1;
         x4 = x4 ^ t2;
         t2 = t2 ^ x2;
         x2 = x3 ^ t1;
         x3 = t2;
         z += 6;
      end
      o.r0 = mulmod(x1, sk[z]);
      o.r1 = x3 + sk[z+1];
      o.r2 = x2 + sk[z+2];
      o.r3 = mulmod(x4, sk[z+3]);
      o.fin = b.last;
      return o;
   endfunction

   // ---------------- drivers ----------------
   task automatic send_block(block_type b, int gap);
      cipher_out_type o;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= b.mode;
      req_word0 <= b.w0; req_word1 <= b.w1; req_word2 <= b.w2; req_word3 <= b.w3;
      req_last_block <= b.last;
      do @(posedge clock); while (!req_ready);
      o = idea_transform(b);
      if (b.mode == MODE_ENC) last_ct = '{o.r0, o.r1, o.r2, o.r3};
      pending_blocks.push_back(o);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [63:0] data);
      req_valid <= 1'b0;
      wait (pending_blocks.size() == 0);
      repeat (20) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_KEY_LOW) key_lo = data;
      else if (idx == CSR_KEY_HIGH) key_hi = data;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic word_type pick_word();
      case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'h0001;
         2: return 16'hffff;
         default: return word_type'($urandom);
      endcase
   endfunction

   // ---------------- receiver stall pattern ----------------
   int stall_style = 0;
   always @(posedge clock) begin
      if (cycles % 97 == 0) stall_style <= int'($urandom_range(0, 3));
      case (stall_style)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= ($urandom_range(0, 7) == 0);
         default: rsp_ready <= ((cycles % 5) != 0);
      endcase
   end

   // ---------------- result checker ----------------
   always @(posedge clock) begin
      cipher_out_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_blocks.size() == 0) begin
            $error("unexpected result beat");
            failed = 1'b1;
         end else begin
            e = pending_blocks.pop_front();
            if (rsp_result0 !== e.r0) begin
               $error("result0 exp %h got %h", e.r0, rsp_result0); failed = 1'b1;
            end
            if (rsp_result1 !== e.r1) begin
               $error("result1 exp %h got %h", e.r1, rsp_result1); failed = 1'b1;
            end
            if (rsp_result2 !== e.r2) begin
               $error("result2 exp %h got %h", e.r2, rsp_result2); failed = 1'b1;
            end
            if (rsp_result3 !== e.r3) begin
               $error("result3 exp %h got %h", e.r3, rsp_result3); failed = 1'b1;
            end
            if (rsp_final_out !== e.fin) begin
               $error("final_out exp %b got %b", e.fin, rsp_final_out); failed = 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_CAP) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // ---------------- stimulus ----------------
   block_type plan[18] = '{
      '{MODE_ENC, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0},
      '{MODE_DEC, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1},
      '{MODE_ENC, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b1},
      '{MODE_DEC, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b0},
      '{MODE_ENC, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 1'b0},
      '{MODE_DEC, 16'h0001, 16'h0000, 16'hffff, 16'h0001, 1'b1},
      '{MODE_ENC, 16'h0000, 16'hffff, 16'h0000, 16'hffff, 1'b0},
      '{MODE_ENC, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 1'b1},
      '{MODE_DEC, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 1'b0},
      '{MODE_ENC, 16'h8000, 16'h7fff, 16'h0100, 16'h00ff, 1'b0},
      '{MODE_ENC, 16'h0000, 16'h0001, 16'h0002, 16'h0003, 1'b1},
      '{MODE_DEC, 16'h0000, 16'h0001, 16'h0002, 16'h0003, 1'b0},
      '{MODE_ENC, 16'hfffe, 16'h0002, 16'h8001, 16'h0000, 1'b0},
      '{MODE_ENC, 16'h1234, 16'h5678, 16'h9abc, 16'hdef0, 1'b0},
      '{MODE_DEC, 16'h1234, 16'h5678, 16'h9abc, 16'hdef0, 1'b1},
      '{MODE_ENC, 16'h0001, 16'h0002, 16'h0003, 16'h0004, 1'b0},
      '{MODE_DEC, 16'hffff, 16'h0000, 16'hffff, 16'h0000, 1'b1},
      '{MODE_ENC, 16'hffff, 16'h0000, 16'h0001, 16'hffff, 1'b1}
   };

   logic [63:0] key_plan[8][2] = '{
      '{64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff},
      '{64'h0004_0003_0002_0001, 64'h0008_0007_0006_0005},
      '{64'h0000_0000_0000_0000, 64'hffff_ffff_ffff_ffff},
      '{64'h0001_0001_0001_0001, 64'h0000_0000_0000_0000},
      '{64'h5555_aaaa_5555_aaaa, 64'haaaa_5555_aaaa_5555},
      '{64'h0, 64'h0}, '{64'h0, 64'h0}, '{64'h0, 64'h0}
   };

   initial begin
      block_type b;
      int burst_left;
      int gap;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset key, then the table under the all-ones key
      foreach (plan[i]) send_block(plan[i], i % 3);
      write_csr(CSR_KEY_LOW, 64'hffff_ffff_ffff_ffff);
      write_csr(CSR_KEY_HIGH, 64'hffff_ffff_ffff_ffff);
      foreach (plan[i]) send_block(plan[i], 0);
      // spare indexes must leave the key alone
      write_csr(CSR_SPARE_A, 64'h1234_5678_9abc_def0);
      write_csr(CSR_SPARE_B, 64'hffff_ffff_ffff_ffff);
      send_block(plan[13], 0);

      burst_left = 0;
      for (int ph = 0; ph < 8; ph++) begin
         if (ph >= 5) begin
            key_plan[ph][0] = {$urandom, $urandom};
            key_plan[ph][1] = {$urandom, $urandom};
         end
         write_csr(CSR_KEY_LOW, key_plan[ph][0]);
         write_csr(CSR_KEY_HIGH, key_plan[ph][1]);
         for (int n = 0; n < 145; n++) begin
            b.last = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 3) == 0) begin
               // decrypt the last ciphertext, or a random block
               b.mode = MODE_DEC;
               if ($urandom_range(0, 1)) begin
                  b.w0 = last_ct[0]; b.w1 = last_ct[1];
                  b.w2 = last_ct[2]; b.w3 = last_ct[3];
               end else begin
                  b.w0 = pick_word(); b.w1 = pick_word();
                  b.w2 = pick_word(); b.w3 = pick_word();
               end
            end else begin
               b.mode = MODE_ENC;
               b.w0 = pick_word(); b.w1 = pick_word();
               b.w2 = pick_word(); b.w3 = pick_word();
            end
            gap = 0;
            if (burst_left == 0) begin
               burst_left = int'($urandom_range(1, 12));
               gap = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 30));
            end
            burst_left--;
            send_block(b, gap);
         end
      end
      req_valid <= 1'b0;

      wait (pending_blocks.size() == 0);
      repeat (800) @(posedge clock);
      if (!failed && pending_blocks.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule : tb_top

`default_nettype wire

// ----- sim.f -----
rtl/idea_pkg.sv
rtl/idea_mul.sv
rtl/idea_key.sv
rtl/idea_block_cipher_unit.sv
tb/sv/tb_top.sv
